[rtl/bole_pkg.sv]
// shared types and codes for the bounded ordered list engine
// no dependencies
`default_nettype none

package bole_pkg;

  localparam int BOLE_CAPACITY = 64;
  localparam int DATA_W        = 32;

  typedef enum logic [2:0] {
    ACT_PUSH_BACK    = 3'd0,
    ACT_PUSH_FRONT   = 3'd1,
    ACT_INSERT       = 3'd2,
    ACT_POP_BACK     = 3'd3,
    ACT_POP_FRONT    = 3'd4,
    ACT_REMOVE_AT    = 3'd5,
    ACT_REMOVE_VALUE = 3'd6,
    ACT_READ_AT      = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_RANGE    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch request and match vector
    logic commit;   // apply shift, update count, load result register
  } bole_cmd_t;

endpackage

`default_nettype wire

[rtl/bole_ctrl.sv]
// controller for the bounded ordered list engine: handshakes and sequencing
// depends on bole_pkg
`default_nettype none

module bole_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output bole_pkg::bole_cmd_t    cmd
);
  import bole_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_ready    = (state_r == S_IDLE);
  assign slot_free   = !out_valid_r || out_ready;
  assign cmd.capture = in_valid && in_ready;
  assign cmd.commit  = (state_r == S_COMMIT) && slot_free;
  assign out_valid   = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (slot_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/bole_dp.sv]
// datapath for the bounded ordered list engine: entry cells, match, shift, result
// depends on bole_pkg
`default_nettype none

module bole_dp #(
  parameter  int CAPACITY = bole_pkg::BOLE_CAPACITY,
  localparam int CW       = $clog2(CAPACITY + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  bole_pkg::bole_cmd_t                cmd,
  input  wire logic [2:0]                    in_action,
  input  wire logic signed [bole_pkg::DATA_W-1:0] in_value,
  input  wire logic [CW-1:0]                 in_position,
  output logic [2:0]                         out_status,
  output logic signed [bole_pkg::DATA_W-1:0] out_data_out,
  output logic [CW-1:0]                      out_count_after
);
  import bole_pkg::*;

  logic [DATA_W-1:0]   cell_r   [CAPACITY];
  logic [DATA_W-1:0]   cell_nxt [CAPACITY];
  logic [CW-1:0]       count_r, count_nxt;
  action_t             act_r;
  logic [DATA_W-1:0]   val_r;
  logic [CW-1:0]       pos_r;
  logic [CAPACITY-1:0] match_r, match_nxt;

  logic [CW-1:0]       at;
  logic [CAPACITY-1:0] ge;
  logic [CAPACITY-1:0] first;
  logic [DATA_W-1:0]   taken;
  logic                grow, shrink, found;
  status_t             status;
  logic                ok;

  status_t             status_r;
  logic [DATA_W-1:0]   data_r;
  logic [CW-1:0]       count_after_r;

  // every cell compares against the incoming value in parallel
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_nxt[i] = (cell_r[i] == in_value) && (CW'(i) < count_r);
    end
  end

  always_comb begin
    unique case (act_r)
      ACT_PUSH_BACK:  at = count_r;
      ACT_PUSH_FRONT: at = '0;
      ACT_POP_BACK:   at = count_r - CW'(1);
      ACT_POP_FRONT:  at = '0;
      default:        at = pos_r;
    endcase
  end

  assign grow   = (act_r == ACT_PUSH_BACK) || (act_r == ACT_PUSH_FRONT) ||
                  (act_r == ACT_INSERT);
  assign shrink = (act_r == ACT_POP_BACK) || (act_r == ACT_POP_FRONT) ||
                  (act_r == ACT_REMOVE_AT) || (act_r == ACT_REMOVE_VALUE);
  assign found  = |match_r;

  // cells at or after the point of change; for remove value, at or after first match
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (act_r == ACT_REMOVE_VALUE) begin
        ge[i] = |(match_r << (CAPACITY - 1 - i));
      end else begin
        ge[i] = (CW'(i) >= at);
      end
    end
    first[0] = ge[0];
    for (int i = 1; i < CAPACITY; i++) begin
      first[i] = ge[i] && !ge[i-1];
    end
  end

  always_comb begin
    taken = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      taken = taken | (cell_r[i] & {DATA_W{first[i]}});
    end
  end

  always_comb begin
    status = ST_OK;
    if (grow) begin
      priority if (at > count_r)                 status = ST_RANGE;
      else if (count_r >= CW'(CAPACITY))         status = ST_FULL;
      else                                       status = ST_OK;
    end else if (count_r == '0) begin
      status = ST_EMPTY;
    end else if ((act_r == ACT_REMOVE_AT) || (act_r == ACT_READ_AT)) begin
      if (pos_r >= count_r) status = ST_RANGE;
    end else if (act_r == ACT_REMOVE_VALUE) begin
      if (!found) status = ST_NOTFOUND;
    end
  end

  assign ok = (status == ST_OK);

  always_comb begin
    count_nxt = count_r;
    if (ok && grow) begin
      count_nxt = count_r + CW'(1);
    end else if (ok && shrink) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // per-cell next value: open a gap, write the new value, or close a gap
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] prev_w;
    logic [DATA_W-1:0] next_w;
    if (g == 0) begin : g_first
      assign prev_w = val_r;
    end else begin : g_rest
      assign prev_w = cell_r[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_w = cell_r[g];
    end else begin : g_inner
      assign next_w = cell_r[g+1];
    end
    always_comb begin
      cell_nxt[g] = cell_r[g];
      if (ok && grow && (CW'(g) > at)) begin
        cell_nxt[g] = prev_w;
      end else if (ok && grow && (CW'(g) == at)) begin
        cell_nxt[g] = val_r;
      end else if (ok && shrink && ge[g]) begin
        cell_nxt[g] = next_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r   <= action_t'(in_action);
      val_r   <= in_value;
      pos_r   <= in_position;
      match_r <= match_nxt;
    end
    if (cmd.commit) begin
      for (int i = 0; i < CAPACITY; i++) begin
        cell_r[i] <= cell_nxt[i];
      end
      status_r      <= status;
      data_r        <= (ok && !grow) ? taken : '0;
      count_after_r <= count_nxt;
    end
  end

  assign out_status      = status_r;
  assign out_data_out    = data_r;
  assign out_count_after = count_after_r;

endmodule

`default_nettype wire

[rtl/bounded_ordered_list_engine.sv]
// top level of the bounded ordered list engine
// depends on bole_pkg, bole_ctrl, bole_dp
`default_nettype none

// ordered list of up to CAPACITY signed 32-bit values kept in a row of cells
// input channel in_valid/in_ready carries one request item: in_action,
//   in_value, in_position (index for insert, remove at and read at)
// result channel out_valid/out_ready returns one item per request:
//   out_status, out_data_out (value removed or read, else zero),
//   out_count_after (entries held after the request)
// each request runs as capture then commit: the accept edge registers the
//   request and compares every cell against in_value in parallel; the commit
//   step shifts all cells by one position and loads the result register
// a new request is taken only once the last one commits (capture/commit
//   sequence of the controller), as each request works on the order the last left
// a finished result sits in the output register while the next request is
//   accepted; if the receiver stalls, that request waits in its commit step
//   until the output register frees up, and the list is left untouched
// failed requests (empty, out of range, not found, full) leave the list as is
// reset clears the count and the handshake state; cell contents are not
//   cleared, since no cell at or beyond the count is ever read
module bounded_ordered_list_engine #(
  parameter  int CAPACITY = bole_pkg::BOLE_CAPACITY,
  localparam int CW       = $clog2(CAPACITY + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [2:0]                    in_action,
  input  wire logic signed [bole_pkg::DATA_W-1:0] in_value,
  input  wire logic [CW-1:0]                 in_position,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [2:0]                         out_status,
  output logic signed [bole_pkg::DATA_W-1:0] out_data_out,
  output logic [CW-1:0]                      out_count_after
);
  import bole_pkg::*;

  bole_cmd_t cmd;

  // sequencing and handshakes
  bole_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // cells, match vector, shift network and result register
  bole_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_action       (in_action),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_status      (out_status),
    .out_data_out    (out_data_out),
    .out_count_after (out_count_after)
  );

endmodule

`default_nettype wire
